// ===== rtl/ocd_pkg.sv =====
// Package for the OLED command decoder: command codes, argument selectors,
// decoder state and result types, reset values. No dependencies.
package ocd_pkg;

  // Graphic RAM geometry
  localparam int PAGES   = 16;
  localparam int COLUMNS = 128;

  // Single-byte command codes and ranges
  localparam logic [7:0] CMD_COL_LO       = 8'h00;
  localparam logic [7:0] CMD_COL_LO_LAST  = 8'h0f;
  localparam logic [7:0] CMD_COL_HI       = 8'h10;
  localparam logic [7:0] CMD_COL_HI_LAST  = 8'h17;
  localparam logic [7:0] CMD_ADDR_PAGE    = 8'h20;
  localparam logic [7:0] CMD_ADDR_VERT    = 8'h21;
  localparam logic [7:0] CMD_SEG_NORMAL   = 8'ha0;
  localparam logic [7:0] CMD_SEG_REMAP    = 8'ha1;
  localparam logic [7:0] CMD_ENTIRE_OFF   = 8'ha4;
  localparam logic [7:0] CMD_ENTIRE_ON    = 8'ha5;
  localparam logic [7:0] CMD_NORMAL       = 8'ha6;
  localparam logic [7:0] CMD_REVERSE      = 8'ha7;
  localparam logic [7:0] CMD_DISP_OFF     = 8'hae;
  localparam logic [7:0] CMD_DISP_ON      = 8'haf;
  localparam logic [7:0] CMD_PAGE         = 8'hb0;
  localparam logic [7:0] CMD_PAGE_LAST    = 8'hbf;
  localparam logic [7:0] CMD_SCAN         = 8'hc0;
  localparam logic [7:0] CMD_SCAN_LAST    = 8'hcf;
  localparam logic [7:0] CMD_NOP          = 8'he3;

  // Two-byte command codes
  localparam logic [7:0] CMD_CONTRAST     = 8'h81;
  localparam logic [7:0] CMD_MUX          = 8'ha8;
  localparam logic [7:0] CMD_OFFSET       = 8'hd3;
  localparam logic [7:0] CMD_DCDC         = 8'had;
  localparam logic [7:0] CMD_OSC          = 8'hd5;
  localparam logic [7:0] CMD_PRECHARGE    = 8'hd9;
  localparam logic [7:0] CMD_VCOM         = 8'hdb;
  localparam logic [7:0] CMD_START        = 8'hdc;

  // Command awaiting its argument byte
  typedef enum logic [3:0] {
    ARG_NONE      = 4'd0,
    ARG_CONTRAST  = 4'd1,
    ARG_MUX       = 4'd2,
    ARG_OFFSET    = 4'd3,
    ARG_DCDC      = 4'd4,
    ARG_OSC       = 4'd5,
    ARG_PRECHARGE = 4'd6,
    ARG_VCOM      = 4'd7,
    ARG_START     = 4'd8
  } arg_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_ARG     = 2'd2
  } status_t;

  typedef struct packed {
    logic [6:0] col_ptr;
    logic [3:0] page_ptr;
    logic       addr_mode;
    logic [7:0] contrast_reg;
    logic       seg_remap;
    logic [6:0] mux_ratio;
    logic       entire_on;
    logic       reverse_flag;
    logic [6:0] disp_offset;
    logic [7:0] dcdc_reg;
    logic       power_on;
    logic       scan_reverse;
    logic [7:0] osc_reg;
    logic [7:0] precharge_reg;
    logic [7:0] vcom_reg;
    logic [6:0] start_line;
    arg_t       pending_arg;
  } ocd_state_t;

  localparam ocd_state_t STATE_RESET = '{
    col_ptr:       7'd0,
    page_ptr:      4'd0,
    addr_mode:     1'b0,
    contrast_reg:  8'h80,
    seg_remap:     1'b0,
    mux_ratio:     7'h7f,
    entire_on:     1'b0,
    reverse_flag:  1'b0,
    disp_offset:   7'd0,
    dcdc_reg:      8'h81,
    power_on:      1'b0,
    scan_reverse:  1'b0,
    osc_reg:       8'h50,
    precharge_reg: 8'h22,
    vcom_reg:      8'h35,
    start_line:    7'd0,
    pending_arg:   ARG_NONE
  };

  typedef struct packed {
    logic       ram_write;
    logic [3:0] ram_page;
    logic [6:0] ram_column;
    logic [7:0] ram_byte;
    status_t    status;
  } ocd_result_t;

endpackage

// ===== rtl/ocd_decode.sv =====
// Combinational decode of one received byte: next controller state and
// the RAM write / status of the item. Depends on ocd_pkg.
module ocd_decode import ocd_pkg::*; (
  input  ocd_state_t  state,
  input  logic        is_data,
  input  logic [7:0]  byte_value,
  output ocd_state_t  state_nxt,
  output ocd_result_t result
);

  logic [4:0] page_inc;
  logic [7:0] col_inc;

  assign page_inc = {1'b0, state.page_ptr} + 5'd1;
  assign col_inc  = {1'b0, state.col_ptr} + 8'd1;

  always_comb begin
    state_nxt         = state;
    result.ram_write  = 1'b0;
    result.ram_page   = 4'd0;
    result.ram_column = 7'd0;
    result.ram_byte   = 8'd0;
    result.status     = ST_OK;

    if (is_data) begin
      // data byte: write at the pointer if inside the RAM, then advance
      state_nxt.pending_arg = ARG_NONE;
      if (({1'b0, state.page_ptr} < 5'(PAGES)) && ({1'b0, state.col_ptr} < 8'(COLUMNS))) begin
        result.ram_write  = 1'b1;
        result.ram_page   = state.page_ptr;
        result.ram_column = state.col_ptr;
        result.ram_byte   = byte_value;
      end
      if (state.addr_mode) begin
        state_nxt.page_ptr = (page_inc >= 5'(PAGES)) ? 4'd0 : page_inc[3:0];
      end else begin
        state_nxt.col_ptr = (col_inc >= 8'(COLUMNS)) ? 7'd0 : col_inc[6:0];
      end
    end else if (state.pending_arg != ARG_NONE) begin
      // argument byte of a two-byte command
      result.status         = ST_ARG;
      state_nxt.pending_arg = ARG_NONE;
      unique case (state.pending_arg)
        ARG_CONTRAST:  state_nxt.contrast_reg  = byte_value;
        ARG_MUX:       state_nxt.mux_ratio     = byte_value[6:0];
        ARG_OFFSET:    state_nxt.disp_offset   = byte_value[6:0];
        ARG_DCDC:      state_nxt.dcdc_reg      = byte_value;
        ARG_OSC:       state_nxt.osc_reg       = byte_value;
        ARG_PRECHARGE: state_nxt.precharge_reg = byte_value;
        ARG_VCOM:      state_nxt.vcom_reg      = byte_value;
        ARG_START:     state_nxt.start_line    = byte_value[6:0];
        default:       state_nxt.pending_arg   = ARG_NONE;
      endcase
    end else begin
      // command byte
      unique case (byte_value) inside
        [CMD_COL_LO:CMD_COL_LO_LAST]: state_nxt.col_ptr[3:0] = byte_value[3:0];
        [CMD_COL_HI:CMD_COL_HI_LAST]: state_nxt.col_ptr[6:4] = byte_value[2:0];
        [CMD_PAGE:CMD_PAGE_LAST]:     state_nxt.page_ptr     = byte_value[3:0];
        [CMD_SCAN:CMD_SCAN_LAST]:     state_nxt.scan_reverse = byte_value[3];
        CMD_ADDR_PAGE, CMD_ADDR_VERT:   state_nxt.addr_mode    = byte_value[0];
        CMD_SEG_NORMAL, CMD_SEG_REMAP:  state_nxt.seg_remap    = byte_value[0];
        CMD_ENTIRE_OFF, CMD_ENTIRE_ON:  state_nxt.entire_on    = byte_value[0];
        CMD_NORMAL, CMD_REVERSE:        state_nxt.reverse_flag = byte_value[0];
        CMD_DISP_OFF, CMD_DISP_ON:      state_nxt.power_on     = byte_value[0];
        CMD_NOP:                        result.status          = ST_OK;
        CMD_CONTRAST:  state_nxt.pending_arg = ARG_CONTRAST;
        CMD_MUX:       state_nxt.pending_arg = ARG_MUX;
        CMD_OFFSET:    state_nxt.pending_arg = ARG_OFFSET;
        CMD_DCDC:      state_nxt.pending_arg = ARG_DCDC;
        CMD_OSC:       state_nxt.pending_arg = ARG_OSC;
        CMD_PRECHARGE: state_nxt.pending_arg = ARG_PRECHARGE;
        CMD_VCOM:      state_nxt.pending_arg = ARG_VCOM;
        CMD_START:     state_nxt.pending_arg = ARG_START;
        default:       result.status = ST_UNKNOWN;
      endcase
    end
  end

endmodule

// ===== rtl/oled_command_decoder_unit.sv =====
// OLED command decoder: result valid in the cycle after input accept.
// Throughput 1 item per cycle; the result register refills in the cycle
// it is taken, so the only stall is a held result with out_tready low.
// Synchronous active-low reset restores controller defaults and empties
// the result register.
// Depends on ocd_pkg and ocd_decode.
module oled_command_decoder_unit import ocd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [3:0] ram_page, [10:4] ram_column,
                                  // [18:11] ram_byte, [20:19] status,
                                  // [21] panel_on, [29:22] contrast_level,
                                  // [30] reverse_video, [31] all_pixels_on,
                                  // [32] vertical_mode, [39:33] column_pointer,
                                  // [43:40] page_pointer, [47:44] zero
  output logic        out_tuser   // [0] ram_write
);

  ocd_state_t  state_r, state_nxt;
  ocd_result_t result;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_user_r;
  logic        accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  ocd_decode u_decode (
    .state      (state_r),
    .is_data    (in_tuser),
    .byte_value (in_tdata),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with the state as it stands after the item
  always_ff @(posedge clk) begin
    if (accept) begin
      out_user_r <= result.ram_write;
      out_data_r <= {4'd0, state_nxt.page_ptr, state_nxt.col_ptr,
                     state_nxt.addr_mode, state_nxt.entire_on,
                     state_nxt.reverse_flag, state_nxt.contrast_reg,
                     state_nxt.power_on, result.status, result.ram_byte,
                     result.ram_column, result.ram_page};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== test/tb.sv =====
// Testbench for oled_command_decoder_unit: directed command/data table, then random streams
// with some noise, checked field by field against a local decoder model and typed-in values.
// Depends on ocd_pkg and the RTL of oled_command_decoder_unit.
`timescale 1ns / 1ps

module tb;
  import ocd_pkg::*;

  localparam bit         REQ_CMD        = 1'b0;
  localparam bit         REQ_DATA       = 1'b1;
  localparam logic [7:0] CMD_UNKNOWN_FF = 8'hff;
  localparam logic [7:0] CMD_UNKNOWN_7F = 8'h7f;
  localparam logic [7:0] CMD_SCAN_REV   = CMD_SCAN + 8'd8;
  localparam int         RANDOM_ITEMS   = 1100;
  localparam int         CYCLE_LIMIT    = 200000;

  // One input item, with an optional typed-in expectation
  typedef struct {
    bit         is_data;
    logic [7:0] value;
    bit         typed;
    bit         ram_write;
    status_t    status;
    logic [6:0] col;
    logic [3:0] page;
  } vector_t;

  typedef struct {
    bit         ram_write;
    logic [3:0] ram_page;
    logic [6:0] ram_column;
    logic [7:0] ram_byte;
    status_t    status;
    bit         panel_on;
    logic [7:0] contrast_level;
    bit         reverse_video;
    bit         all_pixels_on;
    bit         vertical_mode;
    logic [6:0] column_pointer;
    logic [3:0] page_pointer;
  } result_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] byte_value
  logic        in_tuser;   // [0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [3:0] page, [10:4] column, [18:11] byte, [20:19] status,
                           // [21] panel_on, [29:22] contrast, [30] reverse,
                           // [31] all on, [32] vertical, [39:33] col ptr, [43:40] page ptr
  logic        out_tuser;  // [0] ram_write

  ocd_state_t   panel_state = STATE_RESET;
  result_item_t decoded_q[$];
  result_item_t head;
  vector_t      directed_rows[25];
  int           mismatch_count = 0;
  bit           in_burst = 0;
  bit           arg_owed = 0;

  oled_command_decoder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Decoder model: updates panel_state and returns the result of one byte
  function automatic result_item_t decode_byte(input bit is_data, input logic [7:0] b);
    result_item_t r;
    r.ram_write  = 1'b0;
    r.ram_page   = '0;
    r.ram_column = '0;
    r.ram_byte   = '0;
    r.status     = ST_OK;
    if (is_data) begin
      panel_state.pending_arg = ARG_NONE;
      if (panel_state.page_ptr < PAGES && panel_state.col_ptr < COLUMNS) begin
        r.ram_write  = 1'b1;
        r.ram_page   = panel_state.page_ptr;
        r.ram_column = panel_state.col_ptr;
        r.ram_byte   = b;
      end
      if (panel_state.addr_mode)
        panel_state.page_ptr = (int'(panel_state.page_ptr) + 1 >= PAGES) ? 4'd0 :
                               panel_state.page_ptr + 4'd1;
      else
        panel_state.col_ptr = (int'(panel_state.col_ptr) + 1 >= COLUMNS) ? 7'd0 :
                              panel_state.col_ptr + 7'd1;
    end else if (panel_state.pending_arg != ARG_NONE) begin
      // argument byte: stored, never decoded
      case (panel_state.pending_arg)
        ARG_CONTRAST:  panel_state.contrast_reg  = b;
        ARG_MUX:       panel_state.mux_ratio     = b[6:0];
        ARG_OFFSET:    panel_state.disp_offset   = b[6:0];
        ARG_DCDC:      panel_state.dcdc_reg      = b;
        ARG_OSC:       panel_state.osc_reg       = b;
        ARG_PRECHARGE: panel_state.precharge_reg = b;
        ARG_VCOM:      panel_state.vcom_reg      = b;
        ARG_START:     panel_state.start_line    = b[6:0];
        default: ;
      endcase
      panel_state.pending_arg = ARG_NONE;
      r.status = ST_ARG;
    end else if (b <= CMD_COL_LO_LAST) begin
      panel_state.col_ptr[3:0] = b[3:0];
    end else if (b <= CMD_COL_HI_LAST) begin
      panel_state.col_ptr[6:4] = b[2:0];
    end else if (b >= CMD_PAGE && b <= CMD_PAGE_LAST) begin
      panel_state.page_ptr = b[3:0];
    end else if (b >= CMD_SCAN && b <= CMD_SCAN_LAST) begin
      panel_state.scan_reverse = b[3];
    end else begin
      case (b)
        CMD_ADDR_PAGE, CMD_ADDR_VERT:   panel_state.addr_mode    = b[0];
        CMD_SEG_NORMAL, CMD_SEG_REMAP:  panel_state.seg_remap    = b[0];
        CMD_ENTIRE_OFF, CMD_ENTIRE_ON:  panel_state.entire_on    = b[0];
        CMD_NORMAL, CMD_REVERSE:        panel_state.reverse_flag = b[0];
        CMD_DISP_OFF, CMD_DISP_ON:      panel_state.power_on     = b[0];
        CMD_NOP: ;
        CMD_CONTRAST:  panel_state.pending_arg = ARG_CONTRAST;
        CMD_MUX:       panel_state.pending_arg = ARG_MUX;
        CMD_OFFSET:    panel_state.pending_arg = ARG_OFFSET;
        CMD_DCDC:      panel_state.pending_arg = ARG_DCDC;
        CMD_OSC:       panel_state.pending_arg = ARG_OSC;
        CMD_PRECHARGE: panel_state.pending_arg = ARG_PRECHARGE;
        CMD_VCOM:      panel_state.pending_arg = ARG_VCOM;
        CMD_START:     panel_state.pending_arg = ARG_START;
        default:       r.status = ST_UNKNOWN;
      endcase
    end
    r.panel_on       = panel_state.power_on;
    r.contrast_level = panel_state.contrast_reg;
    r.reverse_video  = panel_state.reverse_flag;
    r.all_pixels_on  = panel_state.entire_on;
    r.vertical_mode  = panel_state.addr_mode;
    r.column_pointer = panel_state.col_ptr;
    r.page_pointer   = panel_state.page_ptr;
    return r;
  endfunction

  // Random item: mostly data bytes and single-byte commands, some two-byte commands with their argument, some noise
  function automatic vector_t random_item();
    vector_t v;
    int      pick;
    v.is_data   = REQ_CMD;
    v.value     = 8'($urandom_range(0, 255));
    v.typed     = 1'b0;
    v.ram_write = 1'b0;
    v.status    = ST_OK;
    v.col       = '0;
    v.page      = '0;
    pick = $urandom_range(0, 99);
    if (arg_owed) begin
      // argument byte, now and then broken by a data byte
      arg_owed = 1'b0;
      if (pick < 15) v.is_data = REQ_DATA;
    end else if (pick < 40) begin
      v.is_data = REQ_DATA;
    end else if (pick < 52) begin
      arg_owed = 1'b1;
      case ($urandom_range(0, 7))
        0: v.value = CMD_CONTRAST;
        1: v.value = CMD_MUX;
        2: v.value = CMD_OFFSET;
        3: v.value = CMD_DCDC;
        4: v.value = CMD_OSC;
        5: v.value = CMD_PRECHARGE;
        6: v.value = CMD_VCOM;
        default: v.value = CMD_START;
      endcase
    end else if (pick < 90) begin
      case ($urandom_range(0, 9))
        0: v.value = CMD_COL_LO + 8'($urandom_range(0, 15));
        1: v.value = CMD_COL_HI + 8'($urandom_range(0, 7));
        2: v.value = CMD_ADDR_PAGE + 8'($urandom_range(0, 1));
        3: v.value = CMD_SEG_NORMAL + 8'($urandom_range(0, 1));
        4: v.value = CMD_ENTIRE_OFF + 8'($urandom_range(0, 1));
        5: v.value = CMD_NORMAL + 8'($urandom_range(0, 1));
        6: v.value = CMD_DISP_OFF + 8'($urandom_range(0, 1));
        7: v.value = CMD_PAGE + 8'($urandom_range(0, 15));
        8: v.value = CMD_SCAN + 8'($urandom_range(0, 15));
        default: v.value = CMD_NOP;
      endcase
    end
    // else: any command byte at all, known or not
    return v;
  endfunction

  // Present one item after a random gap (none in a burst), record its expectation on accept
  task automatic send_byte(input vector_t v);
    int           gap;
    result_item_t r;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= v.is_data;
    in_tdata  <= v.value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = decode_byte(v.is_data, v.value);
    if (v.typed) begin
      r.ram_write      = v.ram_write;
      r.status         = v.status;
      r.column_pointer = v.col;
      r.page_pointer   = v.page;
    end
    decoded_q.push_back(r);
  endtask

  // Hold the sender until every expected result has come
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected none actual 0x%0h",
                 $time, out_tdata);
      end else begin
        head = decoded_q.pop_front();
        check_field("ram_write",      head.ram_write,      out_tuser);
        check_field("ram_page",       head.ram_page,       out_tdata[3:0]);
        check_field("ram_column",     head.ram_column,     out_tdata[10:4]);
        check_field("ram_byte",       head.ram_byte,       out_tdata[18:11]);
        check_field("status",         int'(head.status),   out_tdata[20:19]);
        check_field("panel_on",       head.panel_on,       out_tdata[21]);
        check_field("contrast_level", head.contrast_level, out_tdata[29:22]);
        check_field("reverse_video",  head.reverse_video,  out_tdata[30]);
        check_field("all_pixels_on",  head.all_pixels_on,  out_tdata[31]);
        check_field("vertical_mode",  head.vertical_mode,  out_tdata[32]);
        check_field("column_pointer", head.column_pointer, out_tdata[39:33]);
        check_field("page_pointer",   head.page_pointer,   out_tdata[43:40]);
        check_field("tdata pad",      0,                   out_tdata[47:44]);
      end
    end
  end

  // Result side: random stalls, with stretches of none
  initial begin : result_ready
    int stall;
    int taken;
    out_tready = 1'b0;
    taken = 0;
    forever begin
      stall = ((taken % 160) >= 130) ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL oled_command_decoder_unit");
    $finish;
  end

  // Stimulus
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    directed_rows = '{
      '{REQ_DATA, 8'h00,           1'b1, 1'b1, ST_OK,      7'd1, 4'd0},
      '{REQ_CMD,  CMD_UNKNOWN_FF,  1'b1, 1'b0, ST_UNKNOWN, 7'd1, 4'd0},
      '{REQ_CMD,  CMD_CONTRAST,    1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  8'hff,           1'b1, 1'b0, ST_ARG,     7'd1, 4'd0},
      '{REQ_CMD,  CMD_COL_LO_LAST, 1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_COL_HI_LAST, 1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      // last column, pointer wraps to column 0
      '{REQ_DATA, 8'hff,           1'b1, 1'b1, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_PAGE_LAST,   1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_ADDR_VERT,   1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      // last page in vertical mode, page wraps to 0
      '{REQ_DATA, 8'ha5,           1'b1, 1'b1, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_DISP_ON,     1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_REVERSE,     1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_ENTIRE_ON,   1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_SEG_REMAP,   1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_SCAN_REV,    1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_NOP,         1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_MUX,         1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  8'h80,           1'b1, 1'b0, ST_ARG,     7'd0, 4'd0},
      // data byte while an argument is pending drops the command
      '{REQ_CMD,  CMD_START,       1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_DATA, 8'h3c,           1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_UNKNOWN_7F,  1'b1, 1'b0, ST_UNKNOWN, 7'd0, 4'd1},
      '{REQ_CMD,  CMD_ADDR_PAGE,   1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_COL_LO,      1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  CMD_CONTRAST,    1'b0, 1'b0, ST_OK,      7'd0, 4'd0},
      '{REQ_CMD,  8'h00,           1'b1, 1'b0, ST_ARG,     7'd0, 4'd1}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_byte(directed_rows[i]);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      in_burst = (i % 200) >= 170;
      if (i == RANDOM_ITEMS / 2) drain_results();
      send_byte(random_item());
    end
    drain_results();
    repeat (4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS oled_command_decoder_unit");
    end else begin
      $display("FAIL oled_command_decoder_unit");
    end
    $finish;
  end

endmodule
